[rtl/scpmc_pkg.sv]
`default_nettype none
package scpmc_pkg;

  localparam logic [2:0] CM_ZERO   = 3'd0;
  localparam logic [2:0] CM_CONST  = 3'd1;
  localparam logic [2:0] CM_PROP   = 3'd2;
  localparam logic [2:0] CM_FULL   = 3'd3;
  localparam logic [2:0] CM_REMAIN = 3'd4;

  localparam logic [2:0] EM_CONST  = 3'd0;
  localparam logic [2:0] EM_PROP   = 3'd1;
  localparam logic [2:0] EM_FULL   = 3'd2;
  localparam logic [2:0] EM_REMAIN = 3'd3;
  localparam logic [2:0] EM_OVER   = 3'd4;
  localparam logic [2:0] EM_ZERO   = 3'd5;

  localparam logic [2:0] OP_NORMAL    = 3'd0;
  localparam logic [2:0] OP_OVERPOWER = 3'd1;
  localparam logic [2:0] OP_HALT      = 3'd2;
  localparam logic [2:0] OP_NO_CHARGE = 3'd3;
  localparam logic [2:0] OP_CAP_TEST  = 3'd4;

  localparam logic [2:0] TP_CHASSIS_CHARGE = 3'd0;
  localparam logic [2:0] TP_BOOST_CHARGE   = 3'd1;
  localparam logic [2:0] TP_ALL_OFF        = 3'd2;
  localparam logic [2:0] TP_CHASSIS_ONLY   = 3'd3;
  localparam logic [2:0] TP_CHARGE_ONLY    = 3'd4;

  localparam logic [1:0] SEQ_NONE          = 2'd0;
  localparam logic [1:0] SEQ_BOOST_FIRST   = 2'd1;
  localparam logic [1:0] SEQ_NMOS_FIRST    = 2'd2;
  localparam logic [1:0] SEQ_BOTH_OFF      = 2'd3;

  localparam logic [2:0] REG_USER_CHARGE_MODE = 3'd0;
  localparam logic [2:0] REG_USER_EXPECT_MODE = 3'd1;
  localparam logic [2:0] REG_CHARGE_POWER     = 3'd2;
  localparam logic [2:0] REG_EXPECT_POWER     = 3'd3;
  localparam logic [2:0] REG_CHARGE_RATIO     = 3'd4;
  localparam logic [2:0] REG_EXPECT_RATIO     = 3'd5;
  localparam logic [2:0] REG_MAX_POWER        = 3'd6;

  localparam logic [11:0] V_RELEASE_CV = 12'd1520;
  localparam logic [11:0] V_CUTOFF_CV  = 12'd1550;

  localparam logic [9:0] BUF_EMPTY = 10'd5;
  localparam logic [9:0] BUF_LOW   = 10'd10;
  localparam logic [9:0] BUF_MID   = 10'd20;
  localparam logic [9:0] BUF_HIGH  = 10'd30;
  localparam logic [9:0] BUF_FULL  = 10'd50;

  // Division by ten as a multiply by ceil(2^26 / 10); exact for inputs below 2^23.
  localparam logic [22:0] DIV10_RECIP = 23'd6710887;
  localparam int          DIV10_SHIFT = 26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic scale;
    logic div;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [2:0] user_charge_mode;
    logic [2:0] user_expect_mode;
    logic [9:0] charge_power_watts;
    logic [9:0] expect_power_watts;
    logic [8:0] charge_ratio_q8;
    logic [8:0] expect_ratio_q8;
    logic [9:0] max_power_watts;
  } cfg_t;

  function automatic logic signed [19:0] watts_sp(input logic signed [11:0] w);
    return $signed({w, 8'h00});
  endfunction

endpackage
`default_nettype wire

[rtl/supercap_power_mode_controller_top.sv]
// Supercapacitor power-mode controller. Each input transfer is one control tick; it yields
// exactly one output transfer with the charge mode, charge and chassis power setpoints in
// signed 1/256 W, the topology and the switch sequence. An item passes through five steps:
// capture at its input transfer, the ratio multiply, the scale by tenths, the reciprocal
// divide by ten and the final load into the output register. The load waits while the
// output register still holds an untaken result. A new input transfer is taken in the cycle
// after the load, so the block takes no new item before the last one is loaded; the result
// register holds one finished item while the next one is worked on. Registers are written
// over the APB port only while the block is idle: this binds the user, and the block itself
// does not enforce it.
`default_nettype none
module supercap_power_mode_controller_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // operating_mode, cap_voltage_cv, power_buffer, power_limit_watts, zero fill
  input  wire  [39:0] s_tdata,
  // referee_valid
  input  wire  [0:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // charge_mode_now, charger_loop_on, charger_disable_pin, charge_setpoint,
  // chassis_setpoint, topology_now, switch_sequence, zero fill
  output logic [55:0] m_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  scpmc_pkg::cfg_t    cfg;
  scpmc_pkg::cmd_t    cmd;
  scpmc_pkg::status_t status;
  logic               cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.user_charge_mode   <= scpmc_pkg::CM_ZERO;
      cfg.user_expect_mode   <= scpmc_pkg::EM_ZERO;
      cfg.charge_power_watts <= 10'd0;
      cfg.expect_power_watts <= 10'd0;
      cfg.charge_ratio_q8    <= 9'd0;
      cfg.expect_ratio_q8    <= 9'd0;
      cfg.max_power_watts    <= 10'd0;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        scpmc_pkg::REG_USER_CHARGE_MODE: cfg.user_charge_mode   <= pwdata[2:0];
        scpmc_pkg::REG_USER_EXPECT_MODE: cfg.user_expect_mode   <= pwdata[2:0];
        scpmc_pkg::REG_CHARGE_POWER:     cfg.charge_power_watts <= pwdata[9:0];
        scpmc_pkg::REG_EXPECT_POWER:     cfg.expect_power_watts <= pwdata[9:0];
        scpmc_pkg::REG_CHARGE_RATIO:     cfg.charge_ratio_q8    <= pwdata[8:0];
        scpmc_pkg::REG_EXPECT_RATIO:     cfg.expect_ratio_q8    <= pwdata[8:0];
        scpmc_pkg::REG_MAX_POWER:        cfg.max_power_watts    <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      scpmc_pkg::REG_USER_CHARGE_MODE: prdata = {29'd0, cfg.user_charge_mode};
      scpmc_pkg::REG_USER_EXPECT_MODE: prdata = {29'd0, cfg.user_expect_mode};
      scpmc_pkg::REG_CHARGE_POWER:     prdata = {22'd0, cfg.charge_power_watts};
      scpmc_pkg::REG_EXPECT_POWER:     prdata = {22'd0, cfg.expect_power_watts};
      scpmc_pkg::REG_CHARGE_RATIO:     prdata = {23'd0, cfg.charge_ratio_q8};
      scpmc_pkg::REG_EXPECT_RATIO:     prdata = {23'd0, cfg.expect_ratio_q8};
      scpmc_pkg::REG_MAX_POWER:        prdata = {22'd0, cfg.max_power_watts};
      default:                         prdata = 32'd0;
    endcase
  end

  scpmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  scpmc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is still in work");

  a_loop_flags_agree: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3] != m_tdata[4]) &&
                 (m_tdata[3] == (m_tdata[2:0] != scpmc_pkg::CM_ZERO)))
    else $error("charge loop flags disagree with charge mode");

  a_codes_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= scpmc_pkg::CM_REMAIN) &&
                 (m_tdata[47:45] <= scpmc_pkg::TP_CHARGE_ONLY))
    else $error("charge mode or topology code out of range");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !m_tvalid || m_tready)
    else $error("result loaded over an untaken result");
`endif

endmodule
`default_nettype wire

[rtl/scpmc_ctrl.sv]
`default_nettype none
module scpmc_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  input  scpmc_pkg::status_t      status,
  output scpmc_pkg::cmd_t         cmd
);

  scpmc_pkg::state_t state;
  scpmc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scpmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      scpmc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next = scpmc_pkg::ST_MUL;
        end
      end
      scpmc_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = scpmc_pkg::ST_SCALE;
      end
      scpmc_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_next = scpmc_pkg::ST_DIV;
      end
      scpmc_pkg::ST_DIV: begin
        cmd.div = 1'b1;
        state_next = scpmc_pkg::ST_LOAD;
      end
      scpmc_pkg::ST_LOAD: begin
        if (status.out_free) begin
          cmd.load = 1'b1;
          state_next = scpmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scpmc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/scpmc_dp.sv]
`default_nettype none
module scpmc_dp (
  input  wire                     clk,
  input  wire                     rst,
  input  scpmc_pkg::cmd_t         cmd,
  output scpmc_pkg::status_t      status,
  input  scpmc_pkg::cfg_t         cfg,
  input  wire  [39:0]             s_tdata,
  input  wire  [0:0]              s_tuser,
  output logic                    m_tvalid,
  input  wire                     m_tready,
  output logic [55:0]             m_tdata
);

  logic [2:0]  operating_mode;
  logic [11:0] cap_voltage_cv;
  logic [9:0]  power_buffer;
  logic        referee_valid;
  logic [9:0]  power_limit_watts;

  logic [18:0] charge_prod;
  logic [18:0] expect_prod;
  logic [22:0] scaled;
  logic [18:0] quot;

  logic [2:0]         held_charge_mode;
  logic signed [19:0] held_charge_setpoint;
  logic [2:0]         last_topology;

  logic [3:0]         ratio_tenths;
  logic [22:0]        scaled_next;
  logic [45:0]        recip_prod;

  logic               may_change;
  logic [2:0]         user_cm;
  logic [2:0]         user_em;
  logic [2:0]         mode_next;
  logic [2:0]         expect_sel;
  logic [2:0]         topo_next;
  logic [1:0]         seq;
  logic signed [19:0] setpoint_next;
  logic signed [19:0] chassis;
  logic signed [11:0] limit_s;
  logic signed [11:0] cp_s;
  logic signed [11:0] ep_s;
  logic signed [11:0] mp_s;

  assign status.out_free = !m_tvalid || m_tready;

  always_comb begin
    if (power_buffer <= scpmc_pkg::BUF_LOW) begin
      ratio_tenths = 4'd7;
    end else if (power_buffer <= scpmc_pkg::BUF_MID) begin
      ratio_tenths = 4'd8;
    end else begin
      ratio_tenths = 4'd9;
    end
    scaled_next = ({4'b0000, charge_prod} * {19'd0, ratio_tenths}) + 23'd5;
    recip_prod = {23'd0, scaled} * {23'd0, scpmc_pkg::DIV10_RECIP};
  end

  always_comb begin
    limit_s = $signed({2'b00, power_limit_watts});
    cp_s = $signed({2'b00, cfg.charge_power_watts});
    ep_s = $signed({2'b00, cfg.expect_power_watts});
    mp_s = $signed({2'b00, cfg.max_power_watts});
    may_change = (held_charge_mode != scpmc_pkg::CM_ZERO) ||
                 (cap_voltage_cv <= scpmc_pkg::V_RELEASE_CV);
    user_cm = (cfg.user_charge_mode <= scpmc_pkg::CM_REMAIN) ?
              cfg.user_charge_mode : scpmc_pkg::CM_ZERO;
    user_em = (cfg.user_expect_mode <= scpmc_pkg::EM_ZERO) ?
              cfg.user_expect_mode : scpmc_pkg::EM_ZERO;
    mode_next = held_charge_mode;
    expect_sel = scpmc_pkg::EM_ZERO;
    topo_next = last_topology;
    unique case (operating_mode)
      scpmc_pkg::OP_NORMAL: begin
        if (may_change) mode_next = user_cm;
        expect_sel = user_em;
        topo_next = scpmc_pkg::TP_CHASSIS_CHARGE;
      end
      scpmc_pkg::OP_OVERPOWER: begin
        if (may_change) mode_next = scpmc_pkg::CM_FULL;
        expect_sel = scpmc_pkg::EM_OVER;
        topo_next = scpmc_pkg::TP_BOOST_CHARGE;
      end
      scpmc_pkg::OP_HALT: begin
        mode_next = scpmc_pkg::CM_ZERO;
        topo_next = scpmc_pkg::TP_ALL_OFF;
      end
      scpmc_pkg::OP_NO_CHARGE: begin
        mode_next = scpmc_pkg::CM_ZERO;
        expect_sel = scpmc_pkg::EM_FULL;
        topo_next = scpmc_pkg::TP_CHASSIS_ONLY;
      end
      scpmc_pkg::OP_CAP_TEST: begin
        if (may_change) mode_next = scpmc_pkg::CM_FULL;
        topo_next = scpmc_pkg::TP_CHARGE_ONLY;
      end
      default: begin
      end
    endcase
    if (cap_voltage_cv > scpmc_pkg::V_CUTOFF_CV ||
        (power_buffer <= scpmc_pkg::BUF_EMPTY && referee_valid)) begin
      mode_next = scpmc_pkg::CM_ZERO;
    end

    setpoint_next = held_charge_setpoint;
    case (mode_next)
      scpmc_pkg::CM_CONST: begin
        if (power_buffer <= scpmc_pkg::BUF_MID) begin
          setpoint_next = scpmc_pkg::watts_sp(cp_s - 12'sd10);
        end else if (power_buffer <= scpmc_pkg::BUF_HIGH) begin
          setpoint_next = scpmc_pkg::watts_sp(cp_s - 12'sd5);
        end else if (power_buffer >= scpmc_pkg::BUF_FULL) begin
          setpoint_next = scpmc_pkg::watts_sp(cp_s);
        end
      end
      scpmc_pkg::CM_PROP: begin
        if (power_buffer <= scpmc_pkg::BUF_HIGH) begin
          setpoint_next = $signed({1'b0, quot});
        end else if (power_buffer >= scpmc_pkg::BUF_FULL) begin
          setpoint_next = $signed({1'b0, charge_prod});
        end
      end
      scpmc_pkg::CM_FULL: begin
        if (power_buffer <= scpmc_pkg::BUF_LOW) begin
          setpoint_next = scpmc_pkg::watts_sp(limit_s - 12'sd15);
        end else if (power_buffer <= scpmc_pkg::BUF_MID) begin
          setpoint_next = scpmc_pkg::watts_sp(limit_s - 12'sd10);
        end else if (power_buffer <= scpmc_pkg::BUF_HIGH) begin
          setpoint_next = scpmc_pkg::watts_sp(limit_s - 12'sd5);
        end else if (power_buffer >= scpmc_pkg::BUF_FULL) begin
          setpoint_next = scpmc_pkg::watts_sp(limit_s + 12'sd5);
        end
      end
      scpmc_pkg::CM_REMAIN: begin
        setpoint_next = scpmc_pkg::watts_sp(limit_s - ep_s);
      end
      default: begin
      end
    endcase

    case (expect_sel)
      scpmc_pkg::EM_CONST:  chassis = scpmc_pkg::watts_sp(ep_s);
      scpmc_pkg::EM_PROP:   chassis = $signed({1'b0, expect_prod});
      scpmc_pkg::EM_FULL:   chassis = scpmc_pkg::watts_sp(limit_s);
      scpmc_pkg::EM_REMAIN: chassis = scpmc_pkg::watts_sp(limit_s - cp_s);
      scpmc_pkg::EM_OVER:   chassis = scpmc_pkg::watts_sp(mp_s);
      default:              chassis = 20'sd0;
    endcase

    seq = scpmc_pkg::SEQ_NONE;
    if (topo_next != last_topology) begin
      if (topo_next == scpmc_pkg::TP_BOOST_CHARGE) begin
        seq = scpmc_pkg::SEQ_BOOST_FIRST;
      end else if (topo_next == scpmc_pkg::TP_CHASSIS_CHARGE ||
                   topo_next == scpmc_pkg::TP_CHASSIS_ONLY) begin
        seq = scpmc_pkg::SEQ_NMOS_FIRST;
      end else begin
        seq = scpmc_pkg::SEQ_BOTH_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      operating_mode    <= s_tdata[2:0];
      cap_voltage_cv    <= s_tdata[14:3];
      power_buffer      <= s_tdata[24:15];
      power_limit_watts <= s_tdata[34:25];
      referee_valid     <= s_tuser[0];
    end
    if (cmd.mul) begin
      charge_prod <= {9'd0, power_limit_watts} * {10'd0, cfg.charge_ratio_q8};
      expect_prod <= {9'd0, power_limit_watts} * {10'd0, cfg.expect_ratio_q8};
    end
    if (cmd.scale) begin
      scaled <= scaled_next;
    end
    if (cmd.div) begin
      quot <= recip_prod[scpmc_pkg::DIV10_SHIFT +: 19];
    end
    if (cmd.load) begin
      m_tdata <= {6'd0, seq, topo_next, chassis, setpoint_next,
                  (mode_next == scpmc_pkg::CM_ZERO),
                  (mode_next != scpmc_pkg::CM_ZERO), mode_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      held_charge_mode <= scpmc_pkg::CM_ZERO;
      held_charge_setpoint <= 20'sd0;
      last_topology <= scpmc_pkg::TP_ALL_OFF;
    end else begin
      if (cmd.load) begin
        m_tvalid <= 1'b1;
        held_charge_mode <= mode_next;
        held_charge_setpoint <= setpoint_next;
        last_topology <= topo_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[tb/sv/power_mode_checker.sv]
`timescale 1ns / 1ps
module power_mode_checker
  import scpmc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  // operating_mode, cap_voltage_cv, power_buffer, power_limit_watts, zero fill
  input  wire  [39:0] s_tdata,
  // referee_valid
  input  wire  [0:0]  s_tuser,
  input  wire         m_tvalid,
  input  wire         m_tready,
  // charge_mode_now, charger_loop_on, charger_disable_pin, charge_setpoint,
  // chassis_setpoint, topology_now, switch_sequence, zero fill
  input  wire  [55:0] m_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  input  wire         pready,
  output int          errors,
  output int          outstanding
);

  // Members run from the highest bits down, so the struct matches m_tdata[49:0].
  typedef struct packed {
    logic [1:0]  seq;
    logic [2:0]  topo;
    logic [19:0] chassis;
    logic [19:0] charge;
    logic        pin_off;
    logic        loop_on;
    logic [2:0]  mode;
  } tick_out_t;

  cfg_t        cfg;
  logic [2:0]  held_mode;
  int          held_sp;
  logic [2:0]  last_topo;
  tick_out_t   tick_results[$];

  function automatic tick_out_t control_tick(input logic [2:0] op, input logic [11:0] cv,
                                             input logic [9:0] buffer_j, input logic fresh,
                                             input logic [9:0] limit_in);
    tick_out_t  r;
    logic       may_change;
    logic [2:0] emode;
    logic [2:0] topo;
    int         lim;
    int         cp;
    int         ep;
    int         prod;
    int         chassis;
    lim = int'(limit_in);
    cp = int'(cfg.charge_power_watts);
    ep = int'(cfg.expect_power_watts);
    may_change = (held_mode != CM_ZERO) || (cv <= V_RELEASE_CV);
    emode = EM_ZERO;
    topo = last_topo;
    case (op)
      OP_NORMAL: begin
        if (may_change)
          held_mode = (cfg.user_charge_mode <= CM_REMAIN) ? cfg.user_charge_mode : CM_ZERO;
        emode = (cfg.user_expect_mode <= EM_ZERO) ? cfg.user_expect_mode : EM_ZERO;
        topo = TP_CHASSIS_CHARGE;
      end
      OP_OVERPOWER: begin
        if (may_change) held_mode = CM_FULL;
        emode = EM_OVER;
        topo = TP_BOOST_CHARGE;
      end
      OP_HALT: begin
        held_mode = CM_ZERO;
        topo = TP_ALL_OFF;
      end
      OP_NO_CHARGE: begin
        held_mode = CM_ZERO;
        emode = EM_FULL;
        topo = TP_CHASSIS_ONLY;
      end
      OP_CAP_TEST: begin
        if (may_change) held_mode = CM_FULL;
        topo = TP_CHARGE_ONLY;
      end
      default: ;
    endcase

    if (cv > V_CUTOFF_CV || (buffer_j <= BUF_EMPTY && fresh)) held_mode = CM_ZERO;

    // In the constant, proportional and full modes, buffers from 31 to 49 leave the held setpoint untouched.
    case (held_mode)
      CM_CONST: begin
        if (buffer_j <= BUF_MID) held_sp = (cp - 10) * 256;
        else if (buffer_j <= BUF_HIGH) held_sp = (cp - 5) * 256;
        else if (buffer_j >= BUF_FULL) held_sp = cp * 256;
      end
      CM_PROP: begin
        prod = lim * int'(cfg.charge_ratio_q8);
        if (buffer_j <= BUF_LOW) held_sp = (prod * 7 + 5) / 10;
        else if (buffer_j <= BUF_MID) held_sp = (prod * 8 + 5) / 10;
        else if (buffer_j <= BUF_HIGH) held_sp = (prod * 9 + 5) / 10;
        else if (buffer_j >= BUF_FULL) held_sp = prod;
      end
      CM_FULL: begin
        if (buffer_j <= BUF_LOW) held_sp = (lim - 15) * 256;
        else if (buffer_j <= BUF_MID) held_sp = (lim - 10) * 256;
        else if (buffer_j <= BUF_HIGH) held_sp = (lim - 5) * 256;
        else if (buffer_j >= BUF_FULL) held_sp = (lim + 5) * 256;
      end
      CM_REMAIN: held_sp = (lim - ep) * 256;
      default: ;
    endcase

    case (emode)
      EM_CONST:  chassis = ep * 256;
      EM_PROP:   chassis = lim * int'(cfg.expect_ratio_q8);
      EM_FULL:   chassis = lim * 256;
      EM_REMAIN: chassis = (lim - cp) * 256;
      EM_OVER:   chassis = int'(cfg.max_power_watts) * 256;
      default:   chassis = 0;
    endcase

    r.seq = SEQ_NONE;
    if (topo != last_topo) begin
      if (topo == TP_BOOST_CHARGE) r.seq = SEQ_BOOST_FIRST;
      else if (topo == TP_CHASSIS_CHARGE || topo == TP_CHASSIS_ONLY) r.seq = SEQ_NMOS_FIRST;
      else r.seq = SEQ_BOTH_OFF;
    end
    last_topo = topo;

    r.mode = held_mode;
    r.loop_on = (held_mode != CM_ZERO);
    r.pin_off = (held_mode == CM_ZERO);
    r.charge = held_sp[19:0];
    r.chassis = chassis[19:0];
    r.topo = topo;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors = errors + 1;
  endtask

  task automatic check_field(input string name, input logic [19:0] got,
                             input logic [19:0] want);
    if (got !== want) report($sformatf("%s: got %h, want %h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    tick_out_t got;
    tick_out_t want;
    if (rst) begin
      cfg = '{3'd0, EM_ZERO, 10'd0, 10'd0, 9'd0, 9'd0, 10'd0};
      held_mode = CM_ZERO;
      held_sp = 0;
      last_topo = TP_ALL_OFF;
      tick_results.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_USER_CHARGE_MODE: cfg.user_charge_mode = pwdata[2:0];
          REG_USER_EXPECT_MODE: cfg.user_expect_mode = pwdata[2:0];
          REG_CHARGE_POWER:     cfg.charge_power_watts = pwdata[9:0];
          REG_EXPECT_POWER:     cfg.expect_power_watts = pwdata[9:0];
          REG_CHARGE_RATIO:     cfg.charge_ratio_q8 = pwdata[8:0];
          REG_EXPECT_RATIO:     cfg.expect_ratio_q8 = pwdata[8:0];
          REG_MAX_POWER:        cfg.max_power_watts = pwdata[9:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (tick_results.size() == 0) begin
          report($sformatf("result transfer %h with nothing expected", m_tdata));
        end else begin
          want = tick_results.pop_front();
          got = tick_out_t'(m_tdata[49:0]);
          check_field("charge_mode_now", 20'(got.mode), 20'(want.mode));
          check_field("charger_loop_on", 20'(got.loop_on), 20'(want.loop_on));
          check_field("charger_disable_pin", 20'(got.pin_off), 20'(want.pin_off));
          check_field("charge_setpoint", got.charge, want.charge);
          check_field("chassis_setpoint", got.chassis, want.chassis);
          check_field("topology_now", 20'(got.topo), 20'(want.topo));
          check_field("switch_sequence", 20'(got.seq), 20'(want.seq));
          check_field("zero fill", 20'(m_tdata[55:50]), 20'd0);
        end
      end
      if (s_tvalid && s_tready)
        tick_results.push_back(control_tick(s_tdata[2:0], s_tdata[14:3], s_tdata[24:15],
                                            s_tuser[0], s_tdata[34:25]));
      outstanding <= tick_results.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import scpmc_pkg::*;

  localparam int         CYCLE_LIMIT = 300000;
  localparam int         PHASES      = 9;
  localparam int         PHASE_ITEMS = 100;
  localparam logic [2:0] OP_RESERVED = 3'd7;
  localparam logic [2:0] OP_SPARE    = 3'd5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        calm = 1'b0;
  int          errors;
  int          outstanding;
  int          cycles = 0;

  supercap_power_mode_controller_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  power_mode_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .errors(errors), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) m_tready <= calm || ($urandom_range(0, 99) >= 36);

  task automatic send_tick(input logic [2:0] op, input logic [11:0] cv,
                           input logic [9:0] buffer_j, input logic fresh,
                           input logic [9:0] lim);
    while (!calm && $urandom_range(0, 99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, lim, buffer_j, cv, op};
    s_tuser <= fresh;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic new_setting(input cfg_t c);
    drain();
    apb_write(REG_USER_CHARGE_MODE, 32'(c.user_charge_mode));
    apb_write(REG_USER_EXPECT_MODE, 32'(c.user_expect_mode));
    apb_write(REG_CHARGE_POWER, 32'(c.charge_power_watts));
    apb_write(REG_EXPECT_POWER, 32'(c.expect_power_watts));
    apb_write(REG_CHARGE_RATIO, 32'(c.charge_ratio_q8));
    apb_write(REG_EXPECT_RATIO, 32'(c.expect_ratio_q8));
    apb_write(REG_MAX_POWER, 32'(c.max_power_watts));
  endtask

  initial begin : stimulus
    cfg_t        c;
    logic [2:0]  op;
    logic [11:0] cv;
    logic [9:0]  buffer_j;
    logic [9:0]  lim;
    int          pick;
    op = OP_NORMAL;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Constant charge and expectation at the top of their ranges.
    new_setting('{CM_CONST, EM_CONST, 10'd1023, 10'd1023, 9'd256, 9'd256, 10'd1023});
    send_tick(OP_NORMAL, 12'd1600, 10'd100, 1'b1, 10'd1023);
    send_tick(OP_NORMAL, V_RELEASE_CV, 10'd50, 1'b1, 10'd1023);
    send_tick(OP_NORMAL, 12'd1530, 10'd40, 1'b1, 10'd1023);
    send_tick(OP_NORMAL, V_CUTOFF_CV, 10'd30, 1'b1, 10'd1023);
    send_tick(OP_NORMAL, 12'd1551, 10'd20, 1'b1, 10'd1023);
    send_tick(OP_NORMAL, 12'd1521, 10'd21, 1'b0, 10'd1023);
    send_tick(OP_NORMAL, 12'd0, 10'd5, 1'b1, 10'd1023);
    send_tick(OP_NORMAL, 12'd0, 10'd5, 1'b0, 10'd1023);
    send_tick(OP_OVERPOWER, 12'd4095, 10'd1023, 1'b1, 10'd1023);
    send_tick(OP_OVERPOWER, 12'd100, 10'd11, 1'b1, 10'd0);
    send_tick(OP_HALT, 12'd100, 10'd60, 1'b0, 10'd500);
    send_tick(OP_NO_CHARGE, 12'd100, 10'd60, 1'b0, 10'd500);
    send_tick(OP_CAP_TEST, 12'd100, 10'd10, 1'b0, 10'd0);
    send_tick(OP_RESERVED, 12'd1000, 10'd60, 1'b0, 10'd1023);
    send_tick(OP_SPARE, 12'd1600, 10'd0, 1'b1, 10'd1023);

    // Proportional charge across the buffer bands, including the gap.
    new_setting('{CM_PROP, EM_PROP, 10'd0, 10'd0, 9'd256, 9'd256, 10'd0});
    send_tick(OP_NORMAL, 12'd1000, 10'd10, 1'b0, 10'd1023);
    send_tick(OP_NORMAL, 12'd1000, 10'd20, 1'b0, 10'd1023);
    send_tick(OP_NORMAL, 12'd1000, 10'd30, 1'b0, 10'd1023);
    send_tick(OP_NORMAL, 12'd1000, 10'd50, 1'b0, 10'd1023);
    send_tick(OP_NORMAL, 12'd1000, 10'd45, 1'b0, 10'd7);

    // Remaining power with negative results.
    new_setting('{CM_REMAIN, EM_REMAIN, 10'd1023, 10'd1023, 9'd0, 9'd0, 10'd0});
    send_tick(OP_NORMAL, 12'd1000, 10'd0, 1'b0, 10'd0);
    send_tick(OP_NORMAL, 12'd1000, 10'd1023, 1'b1, 10'd1023);

    for (int p = 0; p < PHASES; p++) begin
      c.user_charge_mode = p[2:0];
      c.user_expect_mode = 3'(p * 3);
      if (p == 0) begin
        c.charge_power_watts = 10'd1023;
        c.expect_power_watts = 10'd1023;
        c.charge_ratio_q8 = 9'd256;
        c.expect_ratio_q8 = 9'd256;
        c.max_power_watts = 10'd1023;
      end else if (p == 1) begin
        c.charge_power_watts = 10'd0;
        c.expect_power_watts = 10'd0;
        c.charge_ratio_q8 = 9'd0;
        c.expect_ratio_q8 = 9'd0;
        c.max_power_watts = 10'd0;
      end else begin
        c.charge_power_watts = 10'($urandom_range(0, 1023));
        c.expect_power_watts = 10'($urandom_range(0, 1023));
        c.charge_ratio_q8 = 9'($urandom_range(0, 256));
        c.expect_ratio_q8 = 9'($urandom_range(0, 256));
        c.max_power_watts = 10'($urandom_range(0, 1023));
      end
      new_setting(c);
      calm <= (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) drain();
        pick = $urandom_range(0, 99);
        if (pick < 8) op = 3'($urandom_range(5, 7));
        else if (pick < 55) op = 3'($urandom_range(0, 4));
        cv = (pick % 4 == 0) ? 12'($urandom_range(0, 4095)) :
             (pick % 4 == 1) ? 12'($urandom_range(0, 1520)) : 12'($urandom_range(1490, 1580));
        buffer_j = ($urandom_range(0, 99) < 60) ? 10'($urandom_range(0, 60)) :
                   10'($urandom_range(0, 1023));
        lim = ($urandom_range(0, 99) < 10) ? 10'($urandom_range(0, 20)) :
              10'($urandom_range(0, 1023));
        send_tick(op, cv, buffer_j, 1'($urandom_range(0, 1)), lim);
      end
    end

    drain();
    calm <= 1'b0;
    repeat (20) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
